/* design/sle_pkg.sv */
// Shared types and operation codes for the sorted list engine.
package sle_pkg;

    localparam int ValueWidth = 32;
    localparam int OpWidth    = 3;
    localparam int PosWidth   = 4;
    localparam int CountWidth = 5;

    localparam logic [OpWidth-1:0] OP_INSERT       = 3'd0;
    localparam logic [OpWidth-1:0] OP_REMOVE_FRONT = 3'd1;
    localparam logic [OpWidth-1:0] OP_REMOVE_LAST  = 3'd2;
    localparam logic [OpWidth-1:0] OP_READ_AT      = 3'd3;
    localparam logic [OpWidth-1:0] OP_CLEAR        = 3'd4;

    typedef logic signed [ValueWidth-1:0] value_t;

    typedef struct packed {
        logic   ins;
        logic   pop_front;
        value_t val;
    } sle_cmd_t;

endpackage

/* design/sle_cell.sv */
// One storage cell of the sorted chain: holds one value and shifts with its neighbors.
module sle_cell
    import sle_pkg::*;
(
    input  logic     clk,
    input  sle_cmd_t cmd,
    input  logic     occupied,
    input  logic     left_gt,
    input  value_t   left_data,
    input  value_t   right_data,
    output logic     gt,
    output value_t   data
);

    value_t data_reg;
    value_t data_next;

    assign gt   = !occupied || (data_reg > cmd.val);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (left_gt)
            begin
                data_next = left_data;
            end
            else if (gt)
            begin
                data_next = cmd.val;
            end
        end
        else if (cmd.pop_front)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

/* design/sorted_list_engine_top.sv */
// Top level of the sorted list engine: cell chain, count control and result register.
// The block keeps up to CAPACITY signed 32-bit values in ascending order in a row of cells,
// one value per cell. It takes one transaction per clock cycle while ready and delivers its
// result in the cycle after acceptance; the input is ready whenever the result register is
// empty or is being taken. Insert compares the new value against every cell at once and
// each cell either keeps its value, takes the new value or takes its left neighbor's
// value; remove front shifts every cell one place toward the head. Read at index and remove
// last go through a read multiplexer over the cells, which together with the cell compare
// sets the length of the critical path. Equal values keep their arrival order.
module sorted_list_engine_top
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // value[31:0], position[35:32], zero fill
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // result_value[31:0], count[36:32], zero fill
    output logic [0:0]  m_axis_tuser   // ok[0]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_valid_reg;
    value_t                res_reg;
    value_t                res_next;
    logic                  ok_reg;
    logic                  ok_next;
    logic [CountWidth-1:0] cnt_out_reg;
    logic [CountWidth-1:0] cnt_out_next;

    logic                  accept;
    logic [OpWidth-1:0]    op;
    value_t                val;
    logic [PosWidth-1:0]   pos;
    logic                  full;
    logic                  empty;
    logic [CW+PosWidth-1:0] pos_ext;
    logic [CW+PosWidth-1:0] cnt_ext;
    logic                  pos_ok;
    logic [CW-1:0]         last_cnt;
    logic [IW-1:0]         rd_idx;
    value_t                rd_data;
    logic [CW+CountWidth-1:0] cnt_wide;
    sle_cmd_t              cmd;

    value_t                cell_data [CAPACITY];
    logic                  cell_gt   [CAPACITY];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser;
    assign val           = value_t'(s_axis_tdata[ValueWidth-1:0]);
    assign pos           = s_axis_tdata[ValueWidth+PosWidth-1:ValueWidth];

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_ext  = {{CW{1'b0}}, pos};
    assign cnt_ext  = {{PosWidth{1'b0}}, count_reg};
    assign pos_ok   = (pos_ext < cnt_ext);
    assign last_cnt = count_reg - CW'(1);
    assign rd_idx   = (op == OP_READ_AT) ? pos_ext[IW-1:0] : last_cnt[IW-1:0];
    assign rd_data  = cell_data[rd_idx];

    always_comb
    begin
        cmd.ins       = 1'b0;
        cmd.pop_front = 1'b0;
        cmd.val       = val;
        count_next    = count_reg;
        res_next      = '0;
        ok_next       = 1'b0;
        unique case (op)
            OP_INSERT:
            begin
                if (!full)
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + CW'(1);
                    ok_next    = 1'b1;
                end
            end
            OP_REMOVE_FRONT:
            begin
                if (!empty)
                begin
                    cmd.pop_front = accept;
                    res_next      = cell_data[0];
                    count_next    = last_cnt;
                    ok_next       = 1'b1;
                end
            end
            OP_REMOVE_LAST:
            begin
                if (!empty)
                begin
                    res_next   = rd_data;
                    count_next = last_cnt;
                    ok_next    = 1'b1;
                end
            end
            OP_READ_AT:
            begin
                if (pos_ok)
                begin
                    res_next = rd_data;
                    ok_next  = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign cnt_wide     = {{CountWidth{1'b0}}, count_next};
    assign cnt_out_next = cnt_wide[CountWidth-1:0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   left_gt;
        value_t left_data;
        value_t right_data;

        if (i == 0)
        begin : g_head
            assign left_gt   = 1'b0;
            assign left_data = val;
        end
        else
        begin : g_body
            assign left_gt   = cell_gt[i-1];
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid
            assign right_data = cell_data[i+1];
        end

        sle_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (CW'(i) < count_reg),
            .left_gt    (left_gt),
            .left_data  (left_data),
            .right_data (right_data),
            .gt         (cell_gt[i]),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (s_axis_tready)
            begin
                m_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg     <= res_next;
            ok_reg      <= ok_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, cnt_out_reg, res_reg};
    assign m_axis_tuser  = ok_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("Stored count exceeds capacity.");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_INSERT) && full |=> m_axis_tvalid && !m_axis_tuser[0])
        else $error("Insert into a full list was not refused.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[ValueWidth-1:0] == '0))
        else $error("Failed transaction carries a nonzero value.");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_CLEAR) |=> (count_reg == '0))
        else $error("Clear did not empty the list.");

    for (genvar k = 1; k < CAPACITY; k++)
    begin : g_order_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            (CW'(k) < count_reg) |-> (cell_data[k-1] <= cell_data[k]))
            else $error("Stored values are out of order.");
    end
`endif

endmodule

/* sim/sorted_list_engine_top_tb.sv */
// Self-checking testbench for the sorted list engine with a queue-based list predictor.
`timescale 1ns / 1ps

module sorted_list_engine_top_tb;
    import sle_pkg::*;

    localparam int LIST_CAPACITY = 16;
    localparam logic [OpWidth-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OpWidth-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        value_t                value;
        logic                  ok;
        logic [CountWidth-1:0] count;
    } list_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // value[31:0], position[35:32], zero fill
    logic [2:0]  s_axis_tuser = '0;  // operation[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // result_value[31:0], count[36:32], zero fill
    logic [0:0]  m_axis_tuser;       // ok[0]

    value_t      sorted_shadow[$];
    list_reply_t list_replies_due[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          ops_sent = 0;
    int          replies_checked = 0;
    int          full_rejects = 0;
    int          empty_removals = 0;
    int          mismatches = 0;

    sorted_list_engine_top #(.CAPACITY(LIST_CAPACITY)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic list_reply_t apply_list_op(input logic [OpWidth-1:0] op,
                                                  input value_t val,
                                                  input logic [PosWidth-1:0] pos);
        list_reply_t r;
        int          at;
        r.value = '0;
        r.ok    = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (sorted_shadow.size() < LIST_CAPACITY)
                begin
                    at = 0;
                    while (at < sorted_shadow.size() && sorted_shadow[at] <= val)
                        at++;
                    sorted_shadow.insert(at, val);
                    r.ok = 1'b1;
                end
                else
                    full_rejects++;
            end
            OP_REMOVE_FRONT, OP_REMOVE_LAST:
            begin
                if (sorted_shadow.size() > 0)
                begin
                    r.value = (op == OP_REMOVE_FRONT) ? sorted_shadow.pop_front()
                                                     : sorted_shadow.pop_back();
                    r.ok = 1'b1;
                end
                else
                    empty_removals++;
            end
            OP_READ_AT:
            begin
                if (int'(pos) < sorted_shadow.size())
                begin
                    r.value = sorted_shadow[pos];
                    r.ok    = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                sorted_shadow.delete();
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = CountWidth'(sorted_shadow.size());
        return r;
    endfunction

    task automatic send_list_op(input logic [OpWidth-1:0] op, input value_t val,
                                input logic [PosWidth-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pos, val};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        list_replies_due.push_back(apply_list_op(op, val, pos));
        ops_sent++;
    endtask

    always @(posedge clk)
    begin : check_reply
        list_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (list_replies_due.size() == 0)
            begin
                $display("%0t: result with none expected: value %0d ok %0b count %0d",
                         $time, $signed(m_axis_tdata[31:0]), m_axis_tuser[0],
                         m_axis_tdata[36:32]);
                mismatches++;
            end
            else
            begin
                want = list_replies_due.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                begin
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             want.value, $signed(m_axis_tdata[31:0]));
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.ok)
                begin
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok,
                             m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tdata[36:32] !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count,
                             m_axis_tdata[36:32]);
                    mismatches++;
                end
                replies_checked++;
            end
        end
    end

    function automatic value_t pick_value();
        case ($urandom_range(2))
            0: return value_t'($urandom);
            1: return value_t'(int'($urandom_range(8)) - 4);
            default:
            begin
                case ($urandom_range(3))
                    0: return value_t'(32'h7fff_ffff - $urandom_range(2));
                    1: return value_t'(32'h8000_0000 + $urandom_range(2));
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [OpWidth-1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return OP_INSERT;
        else if (roll < 50)
            return OP_REMOVE_FRONT;
        else if (roll < 65)
            return OP_REMOVE_LAST;
        else if (roll < 90)
            return OP_READ_AT;
        else if (roll < 96)
            return OP_CLEAR;
        else
            return OpWidth'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endfunction

    task automatic test_empty_list();
        send_list_op(OP_REMOVE_FRONT, pick_value(), 4'h0);
        send_list_op(OP_REMOVE_LAST, pick_value(), 4'h0);
        send_list_op(OP_READ_AT, pick_value(), 4'h0);
        send_list_op(OP_CLEAR, pick_value(), 4'hF);
    endtask

    task automatic test_insert_order();
        send_list_op(OP_INSERT, 32'sd5, 4'hF);
        send_list_op(OP_INSERT, 32'h7fff_ffff, 4'h0);
        send_list_op(OP_INSERT, 32'h8000_0000, 4'h0);
        send_list_op(OP_INSERT, '0, 4'h0);
        send_list_op(OP_INSERT, '1, 4'h0);
        send_list_op(OP_INSERT, 32'sd5, 4'h0);
        send_list_op(OP_READ_AT, '0, 4'h0);
        send_list_op(OP_READ_AT, '1, 4'h5);
        send_list_op(OP_READ_AT, '0, 4'h6);
        send_list_op(OP_READ_AT, '0, 4'hF);
        send_list_op(OP_REMOVE_FRONT, '0, 4'h0);
        send_list_op(OP_REMOVE_LAST, '0, 4'h0);
    endtask

    task automatic test_spare_codes();
        logic [OpWidth-1:0] op;
        for (op = OP_SPARE_LO; op != OP_INSERT; op++)
            send_list_op(op, pick_value(), PosWidth'($urandom));
        send_list_op(OP_CLEAR, '0, '0);
    endtask

    task automatic test_full_list();
        repeat (LIST_CAPACITY + 2)
            send_list_op(OP_INSERT, pick_value(), PosWidth'($urandom));
        send_list_op(OP_READ_AT, pick_value(), 4'hF);
        send_list_op(OP_CLEAR, pick_value(), 4'h0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int done;
        int mode;
        int k;
        done = 0;
        while (done < n_items)
        begin
            mode = $urandom_range(9);
            if (mode < 3)
            begin
                k = LIST_CAPACITY - sorted_shadow.size() + $urandom_range(2, 1);
                repeat (k)
                    send_list_op(OP_INSERT, pick_value(), PosWidth'($urandom));
            end
            else if (mode < 5)
            begin
                k = sorted_shadow.size() + 1;
                repeat (k)
                    send_list_op($urandom_range(1) ? OP_REMOVE_FRONT : OP_REMOVE_LAST,
                                 pick_value(), PosWidth'($urandom));
            end
            else
            begin
                k = $urandom_range(20, 4);
                repeat (k)
                    send_list_op(pick_op(), pick_value(), PosWidth'($urandom));
            end
            done += k;
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("sorted_list_engine_top verification failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 61;
        test_empty_list();
        test_insert_order();
        test_spare_codes();
        test_full_list();
        test_random_traffic(360);
        send_idle_pct = 61;
        recv_idle_pct = 13;
        test_random_traffic(380);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(380);
        s_axis_tvalid <= 1'b0;
        while (list_replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Sent %0d list operations and checked %0d results.", ops_sent,
                 replies_checked);
        $display("Inserts refused on a full list: %0d, removals from an empty list: %0d.",
                 full_rejects, empty_removals);
        if (mismatches == 0)
            $display("sorted_list_engine_top verification clean");
        else
            $display("sorted_list_engine_top verification failed");
        $finish;
    end

endmodule
